// ===== rtl/core/co2ps_pkg.sv =====
`default_nettype none

package co2ps_pkg;

   // event kinds carried in req_tuser
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_DONE  = 2'd2;
   localparam logic [1:0] FUNC_BYTE  = 2'd3;

   // bus request codes
   localparam logic [1:0] BUS_NONE  = 2'd0;
   localparam logic [1:0] BUS_WRITE = 2'd1;
   localparam logic [1:0] BUS_READ  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_WRITE     = 3'd1;
   localparam logic [2:0] ERR_READ      = 3'd2;
   localparam logic [2:0] ERR_CRC       = 3'd3;
   localparam logic [2:0] ERR_NOT_READY = 3'd4;

   // sequencer phases
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
   localparam logic [PHASE_W-1:0] PH_POWER_WAIT = 3'd1;
   localparam logic [PHASE_W-1:0] PH_START_WR   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MEAS_WAIT  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_READY_WR   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_READY_RD   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_MEAS_WR    = 3'd6;
   localparam logic [PHASE_W-1:0] PH_MEAS_RD    = 3'd7;

   // csr register indexes
   localparam logic CSR_POWER_ON_DELAY = 1'b0;
   localparam logic CSR_MEASURE_WAIT   = 1'b1;

   localparam logic [15:0] POWER_ON_DELAY_RST = 16'd20;
   localparam logic [15:0] MEASURE_WAIT_RST   = 16'd5200;

   // sensor commands and checks
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [15:0] READY_MASK  = 16'h07FF;
   localparam logic [15:0] CMD_START   = 16'h21B1;
   localparam logic [15:0] CMD_READY   = 16'hE4B8;
   localparam logic [15:0] CMD_MEASURE = 16'hEC05;
   localparam logic [3:0]  READY_BYTES = 4'd3;
   localparam logic [3:0]  MEAS_BYTES  = 4'd9;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [15:0]        wait_count;
      logic [3:0]         byte_pos;
      logic [7:0]         crc;
      logic               crc_failed;
      logic [15:0]        first_word;
   } seq_state_type;

   // field order highest first: enable_pin at bit 0
   typedef struct packed {
      logic [2:0]  error_code;
      logic [15:0] co2_ppm;
      logic        success;
      logic        done_res;
      logic [3:0]  read_count;
      logic [15:0] cmd_word;
      logic [1:0]  bus_cmd;
      logic        enable_pin;
   } rsp_type;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/co2_sensor_poll_sequencer_unit.sv =====
`default_nettype none

// CO2 sensor poll sequencer.
// The req_ channel carries one event per word: the event kind in req_tuser
// (start, millisecond tick, transfer done, received byte) and ok / rx_byte in
// req_tdata. Every accepted event gives exactly one rsp_ word holding the
// enable pin level, an optional bus request (write command word or read N
// bytes) and, at the end of a cycle, the success flag, the CO2 reading in ppm
// or an error code. Delays are set through csr_ (index 0 power-on delay,
// index 1 measurement wait, both in ticks); write them while idle.
// The result is registered: it appears on rsp_ in the cycle after the event
// is accepted. One event per cycle is accepted while the receiver takes each result; the sequencer state and the
// result register are updated together at the acceptance edge.
// When the receiver stalls, the held result stays on rsp_ and req_tready drops
// until it is taken; req_tready is high whenever the result register is empty
// or being drained in the same cycle.
// Reset (synchronous) returns to idle with enable low, empties the result
// register and loads the delays with 20 and 5200 ticks.
module co2_sensor_poll_sequencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: ok [0], rx_byte [8:1], zero fill [15:9]
   input  wire logic [co2ps_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: func [1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: enable_pin [0], bus_cmd [2:1], cmd_word [18:3], read_count [22:19],
   // done_res [23], success [24], co2_ppm [40:25], error_code [43:41], zero fill [47:44]
   output logic [co2ps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata
);
   import co2ps_pkg::*;

   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          valid_ff;
   logic [15:0]   power_delay_ff;
   logic [15:0]   measure_wait_ff;
   logic          accept;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   // one event step
   co2ps_step u_step (
      .cur            (state_ff),
      .func           (req_tuser),
      .ok             (req_tdata[0]),
      .rx_byte        (req_tdata[8:1]),
      .power_on_delay (power_delay_ff),
      .measure_wait   (measure_wait_ff),
      .nxt            (state_in),
      .rsp            (rsp_in)
   );

   // delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_delay_ff  <= POWER_ON_DELAY_RST;
         measure_wait_ff <= MEASURE_WAIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_POWER_ON_DELAY: power_delay_ff  <= csr_wdata;
            default:            measure_wait_ff <= csr_wdata;
         endcase
      end
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, wait_count: '0, byte_pos: '0,
                       crc: CRC_INIT, crc_failed: 1'b0, first_word: '0};
         valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // held result agrees with the phase it left behind
   a_enable_matches_phase: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rsp_ff.enable_pin == (state_ff.phase != PH_IDLE)))
      else $error("enable pin disagrees with sequencer phase");

   // an error is only reported on a failed end of cycle
   a_error_only_on_fail: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ff.error_code != ERR_NONE) |-> (rsp_ff.done_res && !rsp_ff.success))
      else $error("error code outside a failed end of cycle");

   // read position never runs past the longest read
   a_byte_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_pos <= MEAS_BYTES)
      else $error("byte position beyond read length");

   // a finished cycle always drops enable
   a_done_drops_enable: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_in.done_res) |=> (state_ff.phase == PH_IDLE && !rsp_ff.enable_pin))
      else $error("cycle ended with enable still high");

endmodule

`default_nettype wire

// ===== rtl/core/co2ps_step.sv =====
`default_nettype none

module co2ps_step (
   input  wire co2ps_pkg::seq_state_type cur,
   input  wire logic [1:0]               func,
   input  wire logic                     ok,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [15:0]              power_on_delay,
   input  wire logic [15:0]              measure_wait,
   output co2ps_pkg::seq_state_type      nxt,
   output co2ps_pkg::rsp_type            rsp
);
   import co2ps_pkg::*;

   // position within a three-byte word
   function automatic logic [1:0] slot_of(input logic [3:0] pos);
      case (pos)
         4'd0, 4'd3, 4'd6: slot_of = 2'd0;
         4'd1, 4'd4, 4'd7: slot_of = 2'd1;
         default:          slot_of = 2'd2;
      endcase
   endfunction

   logic [3:0] limit;
   logic [2:0] err;
   logic       finish;

   always_comb begin
      nxt    = cur;
      rsp    = '0;
      err    = ERR_NONE;
      finish = 1'b0;
      limit  = (cur.phase == PH_READY_RD) ? READY_BYTES :
               (cur.phase == PH_MEAS_RD) ? MEAS_BYTES : 4'd0;

      case (func)
         // start a cycle only from idle
         FUNC_START: begin
            if (cur.phase == PH_IDLE) begin
               nxt.phase      = PH_POWER_WAIT;
               nxt.wait_count = power_on_delay;
            end
         end
         // count down the delay phases
         FUNC_TICK: begin
            if (cur.phase inside {PH_POWER_WAIT, PH_MEAS_WAIT}) begin
               if (cur.wait_count <= 16'd1) begin
                  nxt.wait_count = '0;
                  rsp.bus_cmd    = BUS_WRITE;
                  if (cur.phase == PH_POWER_WAIT) begin
                     nxt.phase    = PH_START_WR;
                     rsp.cmd_word = CMD_START;
                  end else begin
                     nxt.phase    = PH_READY_WR;
                     rsp.cmd_word = CMD_READY;
                  end
               end else begin
                  nxt.wait_count = cur.wait_count - 16'd1;
               end
            end
         end
         // transfer completion
         FUNC_DONE: begin
            case (cur.phase)
               PH_START_WR: begin
                  if (ok) begin
                     nxt.phase      = PH_MEAS_WAIT;
                     nxt.wait_count = measure_wait;
                  end else begin
                     finish = 1'b1;
                     err    = ERR_WRITE;
                  end
               end
               PH_READY_WR, PH_MEAS_WR: begin
                  if (ok) begin
                     nxt.phase      = (cur.phase == PH_READY_WR) ? PH_READY_RD : PH_MEAS_RD;
                     nxt.byte_pos   = '0;
                     nxt.crc        = CRC_INIT;
                     nxt.crc_failed = 1'b0;
                     rsp.bus_cmd    = BUS_READ;
                     rsp.read_count = (cur.phase == PH_READY_WR) ? READY_BYTES : MEAS_BYTES;
                  end else begin
                     finish = 1'b1;
                     err    = ERR_WRITE;
                  end
               end
               PH_READY_RD: begin
                  if (!ok || cur.byte_pos < READY_BYTES) begin
                     finish = 1'b1;
                     err    = ERR_READ;
                  end else if (cur.crc_failed) begin
                     finish = 1'b1;
                     err    = ERR_CRC;
                  end else if ((cur.first_word & READY_MASK) == 16'd0) begin
                     finish = 1'b1;
                     err    = ERR_NOT_READY;
                  end else begin
                     nxt.phase    = PH_MEAS_WR;
                     rsp.bus_cmd  = BUS_WRITE;
                     rsp.cmd_word = CMD_MEASURE;
                  end
               end
               PH_MEAS_RD: begin
                  finish = 1'b1;
                  if (!ok || cur.byte_pos < MEAS_BYTES) begin
                     err = ERR_READ;
                  end else if (cur.crc_failed) begin
                     err = ERR_CRC;
                  end
               end
               default: begin
               end
            endcase
         end
         // received data byte
         default: begin
            if (cur.byte_pos < limit) begin
               case (slot_of(cur.byte_pos))
                  2'd0:    nxt.crc = crc8_byte(CRC_INIT, rx_byte);
                  2'd1:    nxt.crc = crc8_byte(cur.crc, rx_byte);
                  default: begin
                     if (cur.crc != rx_byte) begin
                        nxt.crc_failed = 1'b1;
                     end
                  end
               endcase
               if (cur.byte_pos == 4'd0) begin
                  nxt.first_word = {rx_byte, 8'h00};
               end else if (cur.byte_pos == 4'd1) begin
                  nxt.first_word = {cur.first_word[15:8], rx_byte};
               end
               nxt.byte_pos = cur.byte_pos + 4'd1;
            end
         end
      endcase

      // end of cycle report
      if (finish) begin
         nxt.phase      = PH_IDLE;
         rsp.done_res   = 1'b1;
         rsp.success    = (err == ERR_NONE);
         rsp.co2_ppm    = (err == ERR_NONE) ? cur.first_word : 16'd0;
         rsp.error_code = err;
      end

      rsp.enable_pin = (nxt.phase != PH_IDLE);
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   import co2ps_pkg::*;

   // where a measurement cycle is broken off on purpose
   typedef enum int {
      BRK_NONE,
      BRK_START_WR,
      BRK_READY_WR,
      BRK_READY_RD_FAIL,
      BRK_READY_SHORT,
      BRK_READY_CRC,
      BRK_NOT_READY,
      BRK_CRC_NOT_READY,
      BRK_MEAS_WR,
      BRK_MEAS_RD_FAIL,
      BRK_MEAS_SHORT,
      BRK_MEAS_CRC
   } break_kind_type;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_ITEMS    = 70;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [15:0] csr_wdata = '0;

   // sequencer state as the testbench tracks it
   logic [PHASE_W-1:0] seq_phase = PH_IDLE;
   logic [15:0]        ticks_left = '0;
   logic [3:0]         rx_index = '0;
   logic [7:0]         rx_crc = CRC_INIT;
   logic               rx_crc_bad = 1'b0;
   logic [15:0]        lead_word = '0;
   logic [15:0]        power_on_ticks = POWER_ON_DELAY_RST;
   logic [15:0]        measure_ticks = MEASURE_WAIT_RST;

   rsp_type awaited_reports[$];
   int      error_count = 0;
   int      events_sent = 0;
   int      stray_events = 0;
   bit      burst_mode = 1'b0;
   bit      hold_off_pending = 1'b0;

   co2_sensor_poll_sequencer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // crc-8, one data bit at a time, msb first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      int         i;
      c = crc;
      for (i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   // mostly short, now and then long
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] random_delay();
      return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
   endfunction

   // advance the tracked sequencer by one event, return the expected word
   function automatic rsp_type next_poll_result(input logic [1:0] func, input logic ok,
                                                input logic [7:0] rx);
      rsp_type    r;
      logic       ends;
      logic [2:0] code;
      logic [3:0] read_len;
      logic [3:0] limit;
      int         slot;
      r = '0;
      ends = 1'b0;
      code = ERR_NONE;
      read_len = '0;
      case (func)
         FUNC_START: begin
            if (seq_phase == PH_IDLE) begin
               seq_phase = PH_POWER_WAIT;
               ticks_left = power_on_ticks;
            end
         end
         FUNC_TICK: begin
            if (seq_phase == PH_POWER_WAIT || seq_phase == PH_MEAS_WAIT) begin
               if (ticks_left <= 16'd1) begin
                  ticks_left = '0;
                  r.bus_cmd = BUS_WRITE;
                  if (seq_phase == PH_POWER_WAIT) begin
                     r.cmd_word = CMD_START;
                     seq_phase = PH_START_WR;
                  end else begin
                     r.cmd_word = CMD_READY;
                     seq_phase = PH_READY_WR;
                  end
               end else begin
                  ticks_left = ticks_left - 16'd1;
               end
            end
         end
         FUNC_DONE: begin
            case (seq_phase)
               PH_START_WR: begin
                  if (ok) begin
                     seq_phase = PH_MEAS_WAIT;
                     ticks_left = measure_ticks;
                  end else begin
                     ends = 1'b1;
                     code = ERR_WRITE;
                  end
               end
               PH_READY_WR: begin
                  if (ok) begin
                     seq_phase = PH_READY_RD;
                     read_len = READY_BYTES;
                  end else begin
                     ends = 1'b1;
                     code = ERR_WRITE;
                  end
               end
               PH_MEAS_WR: begin
                  if (ok) begin
                     seq_phase = PH_MEAS_RD;
                     read_len = MEAS_BYTES;
                  end else begin
                     ends = 1'b1;
                     code = ERR_WRITE;
                  end
               end
               PH_READY_RD: begin
                  ends = 1'b1;
                  if (!ok || rx_index < READY_BYTES) code = ERR_READ;
                  else if (rx_crc_bad) code = ERR_CRC;
                  else if ((lead_word & READY_MASK) == 16'd0) code = ERR_NOT_READY;
                  else begin
                     ends = 1'b0;
                     seq_phase = PH_MEAS_WR;
                     r.bus_cmd = BUS_WRITE;
                     r.cmd_word = CMD_MEASURE;
                  end
               end
               PH_MEAS_RD: begin
                  ends = 1'b1;
                  if (!ok || rx_index < MEAS_BYTES) code = ERR_READ;
                  else if (rx_crc_bad) code = ERR_CRC;
               end
               default: begin
               end
            endcase
         end
         default: begin
            limit = (seq_phase == PH_READY_RD) ? READY_BYTES :
                    (seq_phase == PH_MEAS_RD) ? MEAS_BYTES : 4'd0;
            if (rx_index < limit) begin
               // two data bytes then the crc byte of each word
               slot = rx_index % 3;
               if (slot == 0) rx_crc = crc8_step(CRC_INIT, rx);
               else if (slot == 1) rx_crc = crc8_step(rx_crc, rx);
               else if (rx_crc != rx) rx_crc_bad = 1'b1;
               if (rx_index == 4'd0) lead_word = {rx, 8'h00};
               else if (rx_index == 4'd1) lead_word[7:0] = rx;
               rx_index = rx_index + 4'd1;
            end
         end
      endcase
      // a new read clears the byte and crc tracking
      if (read_len != 4'd0) begin
         rx_index = '0;
         rx_crc = CRC_INIT;
         rx_crc_bad = 1'b0;
         r.bus_cmd = BUS_READ;
         r.read_count = read_len;
      end
      if (ends) begin
         seq_phase = PH_IDLE;
         r.done_res = 1'b1;
         r.success = (code == ERR_NONE);
         r.co2_ppm = (code == ERR_NONE) ? lead_word : 16'd0;
         r.error_code = code;
      end
      r.enable_pin = (seq_phase != PH_IDLE);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // result check and prediction at each rising edge
   always @(posedge clock) begin : report_check
      rsp_type got_word;
      rsp_type want_word;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_word = rsp_type'(rsp_tdata[43:0]);
            if (awaited_reports.size() == 0) begin
               error_count++;
               $display("%0t ns: result word mismatch, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want_word = awaited_reports.pop_front();
               check_field("enable_pin", 16'(want_word.enable_pin), 16'(got_word.enable_pin));
               check_field("bus_cmd", 16'(want_word.bus_cmd), 16'(got_word.bus_cmd));
               check_field("cmd_word", want_word.cmd_word, got_word.cmd_word);
               check_field("read_count", 16'(want_word.read_count), 16'(got_word.read_count));
               check_field("done_res", 16'(want_word.done_res), 16'(got_word.done_res));
               check_field("success", 16'(want_word.success), 16'(got_word.success));
               check_field("co2_ppm", want_word.co2_ppm, got_word.co2_ppm);
               check_field("error_code", 16'(want_word.error_code),
                           16'(got_word.error_code));
               check_field("zero fill", 16'd0, 16'(rsp_tdata[47:44]));
            end
         end
         if (req_tvalid && req_tready)
            awaited_reports.push_back(next_poll_result(req_tuser, req_tdata[0],
                                                       req_tdata[8:1]));
      end
   end

   // result side: random stalls, long hold-off on request
   initial begin : drain_side
      int stall;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
            stall = idle_length();
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one event word and wait until it is taken
   task automatic send_event(input logic [1:0] func, input logic ok, input logic [7:0] rx);
      int gap;
      gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {7'd0, rx, ok};
      events_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // an event that the current phase does not act on
   task automatic send_stray(input bit allow_start, input bit allow_tick,
                             input bit allow_byte, input bit allow_done);
      logic [1:0] func;
      do func = 2'($urandom_range(0, 3));
      while (!((func == FUNC_START && allow_start) || (func == FUNC_TICK && allow_tick) ||
               (func == FUNC_BYTE && allow_byte) || (func == FUNC_DONE && allow_done)));
      stray_events++;
      send_event(func, 1'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_delay(input logic idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POWER_ON_DELAY) power_on_ticks = val;
      else measure_ticks = val;
   endtask

   task automatic apply_delays(input logic [15:0] power_on, input logic [15:0] measure);
      wait_drained();
      write_delay(CSR_POWER_ON_DELAY, power_on);
      write_delay(CSR_MEASURE_WAIT, measure);
   endtask

   // a delay of zero still takes one tick
   task automatic send_ticks(input logic [15:0] count, input bit noisy);
      repeat ((count == 16'd0) ? 1 : count) begin
         if (noisy && $urandom_range(0, 7) == 0) send_stray(1'b1, 1'b0, 1'b1, 1'b1);
         send_event(FUNC_TICK, 1'($urandom), 8'($urandom));
      end
   endtask

   // bytes of a read: words with their crc, optionally damaged or cut short
   task automatic send_read(input logic [3:0] count, input logic [15:0] first,
                            input bit corrupt, input bit short_read, input bit extra);
      logic [7:0]  stream[$];
      logic [15:0] w;
      int          k;
      int          keep;
      for (k = 0; k < count / 3; k++) begin
         w = (k == 0) ? first : 16'($urandom);
         stream.push_back(w[15:8]);
         stream.push_back(w[7:0]);
         stream.push_back(word_crc(w));
      end
      if (corrupt) begin
         k = 3 * $urandom_range(0, count / 3 - 1) + 2;
         stream[k] = stream[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (short_read) begin
         keep = $urandom_range(0, count - 1);
         while (stream.size() > keep) void'(stream.pop_back());
      end else if (extra) begin
         repeat ($urandom_range(1, 3)) stream.push_back(8'($urandom));
      end
      foreach (stream[i]) send_event(FUNC_BYTE, 1'($urandom), stream[i]);
   endtask

   // one measurement cycle from start request to its end
   task automatic run_cycle(input break_kind_type brk, input logic [15:0] co2,
                            input bit noisy);
      logic [15:0] status;
      status = 16'($urandom);
      if (brk == BRK_NOT_READY || brk == BRK_CRC_NOT_READY) status[10:0] = '0;
      else if (status[10:0] == 11'd0) status[0] = 1'b1;

      send_event(FUNC_START, 1'($urandom), 8'($urandom));
      if (noisy) send_event(FUNC_START, 1'($urandom), 8'($urandom));
      send_ticks(power_on_ticks, noisy);
      if (noisy) send_stray(1'b1, 1'b1, 1'b1, 1'b0);
      send_event(FUNC_DONE, brk != BRK_START_WR, 8'($urandom));
      if (brk == BRK_START_WR) return;

      send_ticks(measure_ticks, noisy);
      if (noisy) send_stray(1'b1, 1'b1, 1'b1, 1'b0);
      send_event(FUNC_DONE, brk != BRK_READY_WR, 8'($urandom));
      if (brk == BRK_READY_WR) return;

      // ready poll
      if (noisy) send_stray(1'b1, 1'b1, 1'b0, 1'b0);
      send_read(READY_BYTES, status, brk == BRK_READY_CRC || brk == BRK_CRC_NOT_READY,
                brk == BRK_READY_SHORT, noisy);
      send_event(FUNC_DONE, brk != BRK_READY_RD_FAIL, 8'($urandom));
      if (brk >= BRK_READY_RD_FAIL && brk <= BRK_CRC_NOT_READY) return;

      // measurement read
      if (noisy) send_stray(1'b1, 1'b1, 1'b1, 1'b0);
      send_event(FUNC_DONE, brk != BRK_MEAS_WR, 8'($urandom));
      if (brk == BRK_MEAS_WR) return;
      send_read(MEAS_BYTES, co2, brk == BRK_MEAS_CRC, brk == BRK_MEAS_SHORT, noisy);
      send_event(FUNC_DONE, brk != BRK_MEAS_RD_FAIL, 8'($urandom));
      if (noisy) send_stray(1'b0, 1'b1, 1'b1, 1'b1);
   endtask

   // power-on delay as it comes out of reset, cycle ended at the first write
   task automatic test_reset_values();
      burst_mode = 1'b1;
      run_cycle(BRK_START_WR, 16'd415, 1'b0);
      burst_mode = 1'b0;
   endtask

   // events with nothing to act on while idle
   task automatic test_idle_events();
      send_event(FUNC_TICK, 1'b0, 8'h00);
      send_event(FUNC_DONE, 1'b1, 8'hFF);
      send_event(FUNC_DONE, 1'b0, 8'h00);
      send_event(FUNC_BYTE, 1'b1, 8'h00);
      send_event(FUNC_BYTE, 1'b0, 8'hFF);
   endtask

   // zero, one and longer delays, extreme readings
   task automatic test_delay_edges();
      apply_delays(16'd0, 16'd0);
      run_cycle(BRK_NONE, 16'hFFFF, 1'b0);
      run_cycle(BRK_NONE, 16'h0000, 1'b0);
      burst_mode = 1'b1;
      apply_delays(16'd5, 16'd4);
      run_cycle(BRK_NONE, 16'h8001, 1'b0);
      burst_mode = 1'b0;
      apply_delays(16'd1, 16'd1);
      run_cycle(BRK_NONE, 16'h7FFE, 1'b0);
   endtask

   // every way a cycle can end in error
   task automatic test_failures();
      int k;
      apply_delays(16'd2, 16'd3);
      for (k = BRK_START_WR; k <= BRK_MEAS_CRC; k++)
         run_cycle(break_kind_type'(k), 16'($urandom), 1'b0);
   endtask

   // starts while busy, ticks and bytes outside their phase, extra bytes
   task automatic test_stray_events();
      run_cycle(BRK_NONE, 16'($urandom), 1'b1);
      run_cycle(BRK_MEAS_SHORT, 16'($urandom), 1'b1);
      run_cycle(BRK_NONE, 16'($urandom), 1'b1);
   endtask

   // result side held off while events keep coming
   task automatic test_backpressure();
      wait_drained();
      hold_off_pending = 1'b1;
      run_cycle(BRK_NONE, 16'($urandom), 1'b1);
      run_cycle(BRK_READY_CRC, 16'($urandom), 1'b0);
   endtask

   task automatic test_random();
      int             base;
      int             cycle_count;
      break_kind_type brk;
      base = events_sent - stray_events;
      cycle_count = 0;
      while (events_sent - stray_events - base < RANDOM_ITEMS) begin
         if (cycle_count % 3 == 2) apply_delays(random_delay(), random_delay());
         burst_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_stray(1'b0, 1'b1, 1'b1, 1'b1);
         brk = ($urandom_range(0, 99) < 65) ? BRK_NONE :
               break_kind_type'($urandom_range(BRK_START_WR, BRK_MEAS_CRC));
         run_cycle(brk, 16'($urandom), $urandom_range(0, 3) == 0);
         cycle_count++;
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_idle_events();
      test_delay_edges();
      test_failures();
      test_stray_events();
      test_backpressure();
      test_random();
      wait_drained();
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
